@@ hdl/gbs_pkg.sv @@
// Package for the grayscale background subtractor.
// Holds the word types, sizes, register indexes and state layout.
// No dependencies.
package gbs_pkg;

  localparam int unsigned FRAME_PIXELS     = 262144;
  localparam int unsigned DEVIATION_FACTOR = 4;
  localparam int unsigned ADDR_W           = $clog2(FRAME_PIXELS);
  localparam int unsigned FACTOR_W         = $clog2(DEVIATION_FACTOR + 1);

  // Register indexes and reset values
  localparam logic [1:0]  REG_LEARNING_RATE     = 2'd0;
  localparam logic [1:0]  REG_GHOST_THRESHOLD   = 2'd1;
  localparam logic [1:0]  REG_INITIAL_DEVIATION = 2'd2;
  localparam logic [15:0] LEARNING_RATE_RST     = 16'd3277;
  localparam logic [7:0]  GHOST_THRESHOLD_RST   = 8'd50;
  localparam logic [15:0] INITIAL_DEVIATION_RST = 16'd5120;

  localparam logic [7:0]  LEVEL_MAX = 8'd255;
  localparam logic [7:0]  COUNT_MAX = 8'd255;

  // Square root: 34-bit radicand, one root bit per stage
  localparam int unsigned SQRT_IN_W  = 34;
  localparam int unsigned SQRT_STEPS = SQRT_IN_W / 2;
  localparam int unsigned REM_W      = SQRT_STEPS + 2;
  // Stages after the read stage: products, sums, radicand, root steps
  localparam int unsigned PIPE_STAGES = 3 + SQRT_STEPS;

  localparam int unsigned STATE_W = 40;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
    logic       last_in_frame;
  } in_word_t;

  typedef struct packed {
    logic foreground;
    logic last_in_frame_out;
  } out_word_t;

  // Per-pixel state as stored in memory
  typedef struct packed {
    logic [7:0]  count;
    logic [15:0] deviation;
    logic [15:0] mean;
  } pix_state_t;

  // Write-back context carried down the update pipeline
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              upd;
    logic [7:0]        count;
    logic [15:0]       mean;
    logic [15:0]       deviation;
  } wb_ctx_t;

endpackage

@@ hdl/gbs_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gaussian_background_subtractor.sv @@
// Top level of the grayscale running-Gaussian background subtractor.
// Depends on gbs_pkg and gbs_ram.
//
//  channel | signals                          | direction | word
//  input   | in_valid_i/in_ready_o/in_data_i  | in        | mode, pixel, last_in_frame
//  result  | out_valid_o/out_ready_i/out_data_o | out     | foreground, last_in_frame_out
//  config  | cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i | in | register write
//
// One pixel per cycle while results are taken and addresses are distinct.
// A result passes the read stage and output register; state write-back comes
// at the end of the update pipe. A pixel whose address is still in the
// read-modify-write pipe (frames of fewer than 22 pixels) waits until that
// write lands: the 17-step root pipeline sets that distance. Reset clears
// control and configuration; memory needs no clearing. A stalled result holds
// one word in the output register and one in the read stage, then input ready drops.
module gaussian_background_subtractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gbs_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbs_pkg::out_word_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int unsigned AW = gbs_pkg::ADDR_W;
  localparam int unsigned NS = gbs_pkg::PIPE_STAGES;
  localparam int unsigned SQ = gbs_pkg::SQRT_STEPS;
  localparam int unsigned RW = gbs_pkg::REM_W;
  localparam int unsigned FW = gbs_pkg::FACTOR_W;

  // Configuration registers
  logic [15:0] rate_q, idev_q;
  logic [7:0]  thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= gbs_pkg::LEARNING_RATE_RST;
      thr_q  <= gbs_pkg::GHOST_THRESHOLD_RST;
      idev_q <= gbs_pkg::INITIAL_DEVIATION_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbs_pkg::REG_LEARNING_RATE:     rate_q <= cfg_data_i;
        gbs_pkg::REG_GHOST_THRESHOLD:   thr_q  <= cfg_data_i[7:0];
        gbs_pkg::REG_INITIAL_DEVIATION: idev_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and pipeline registers
  logic [AW-1:0]       addr_q, addr_d;
  logic                s1_valid_q;
  logic [AW-1:0]       s1_addr_q;
  gbs_pkg::in_word_t   s1_word_q;
  logic                out_valid_q;
  gbs_pkg::out_word_t  out_q;
  gbs_pkg::wb_ctx_t    ctx_q [NS];
  logic [NS-1:0]       ctx_vld_q;

  logic                accept, s1_adv, hazard;
  gbs_pkg::pix_state_t rd_state, wr_state;
  logic                wr_en;

  // Hazard: incoming address still pending in the read stage or update pipe
  always_comb begin
    hazard = s1_valid_q && (s1_addr_q == addr_q);
    for (int i = 0; i < NS; i++) begin
      if (ctx_vld_q[i] && (ctx_q[i].addr == addr_q)) begin
        hazard = 1'b1;
      end
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (!s1_valid_q || s1_adv) && !hazard;
  assign accept     = in_valid_i && in_ready_o;

  // Raster address
  always_comb begin
    if (in_data_i.last_in_frame || (addr_q == AW'(gbs_pkg::FRAME_PIXELS - 1))) begin
      addr_d = '0;
    end else begin
      addr_d = addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        addr_q <= addr_d;
      end
      s1_valid_q  <= accept || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= addr_q;
      s1_word_q <= in_data_i;
    end
  end

  // State memory: count, deviation and mean in one word
  gbs_ram #(
    .WIDTH (gbs_pkg::STATE_W),
    .DEPTH (gbs_pkg::FRAME_PIXELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ctx_q[NS-1].addr),
    .wdata_i (wr_state),
    .re_i    (accept),
    .raddr_i (addr_q),
    .rdata_o (rd_state)
  );

  // Read stage: bounds, classification, ghost counter, first products
  logic [FW+15:0] dev_f;
  logic [FW+16:0] lo_v, hi_v;
  logic [8:0]     lo_r;
  logic [7:0]     lo_lvl, hi_lvl, cnt_inc, cnt_new;
  logic           fg_raw, fg, upd;
  logic [15:0]    x, ad;
  logic [16:0]    nrate;
  logic [16:0]    diff;

  always_comb begin
    dev_f  = rd_state.deviation * FW'(gbs_pkg::DEVIATION_FACTOR);
    lo_v   = {{(FW+1){1'b0}}, rd_state.mean} - {1'b0, dev_f} + (FW+17)'(128);
    hi_v   = {{(FW+1){1'b0}}, rd_state.mean} + {1'b0, dev_f} + (FW+17)'(128);
    if ({{FW{1'b0}}, rd_state.mean} <= dev_f) begin
      lo_r = '0;
    end else begin
      lo_r = lo_v[16:8];
    end
    lo_lvl = lo_r[8] ? gbs_pkg::LEVEL_MAX : lo_r[7:0];
    hi_lvl = (hi_v[FW+16:8] > (FW+9)'(gbs_pkg::LEVEL_MAX)) ? gbs_pkg::LEVEL_MAX
                                                         : hi_v[15:8];
    fg_raw  = (s1_word_q.pixel < lo_lvl) || (s1_word_q.pixel > hi_lvl);
    cnt_inc = (rd_state.count == gbs_pkg::COUNT_MAX) ? rd_state.count
                                                     : rd_state.count + 8'd1;
    cnt_new = fg_raw ? cnt_inc : 8'd0;
    fg      = s1_word_q.mode && fg_raw && !(cnt_new > thr_q);
    upd     = s1_word_q.mode && !fg;
    x       = {s1_word_q.pixel, 8'd0};
    nrate   = 17'h10000 - {1'b0, rate_q};
    diff    = {1'b0, x} - {1'b0, rd_state.mean};
    ad      = diff[16] ? 16'(-diff) : diff[15:0];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.foreground        <= fg;
      out_q.last_in_frame_out <= s1_word_q.last_in_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Product stage
  logic [31:0] ax_q, ad2_q, s2_q;
  logic [32:0] nam_q;
  logic [15:0] a_q;
  logic [16:0] na_q;

  always_ff @(posedge clk_i) begin
    ax_q  <= rate_q * x;
    nam_q <= nrate * rd_state.mean;
    ad2_q <= ad * ad;
    s2_q  <= rd_state.deviation * rd_state.deviation;
    a_q   <= rate_q;
    na_q  <= nrate;
  end

  // Weighted sums and the radicand
  logic [16:0] nm_sum;
  logic [15:0] nm_q;
  logic [47:0] va_q;
  logic [48:0] vb_q;
  logic [33:0] n_q;
  logic [49:0] var_sum;

  assign nm_sum  = 17'(({1'b0, ax_q} + nam_q + 33'd32768) >> 16);
  assign var_sum = {2'b0, va_q} + {1'b0, vb_q};

  always_ff @(posedge clk_i) begin
    nm_q <= nm_sum[16] ? 16'hFFFF : nm_sum[15:0];
    va_q <= a_q * ad2_q;
    vb_q <= na_q * s2_q;
    n_q  <= var_sum[47:14];
  end

  // Root pipeline: one root bit per stage
  logic [RW-1:0]                rem_q  [SQ];
  logic [SQ-1:0]                root_q [SQ];
  logic [gbs_pkg::SQRT_IN_W-1:0] nsh_q [SQ];
  logic [RW-1:0]                rem_d  [SQ];
  logic [SQ-1:0]                root_d [SQ];
  logic [gbs_pkg::SQRT_IN_W-1:0] nsh_d [SQ];

  always_comb begin
    logic [RW+1:0]                 cur;
    logic [RW+1:0]                 trial;
    logic [RW-1:0]                 rem_p;
    logic [SQ-1:0]                 root_p;
    logic [gbs_pkg::SQRT_IN_W-1:0] n_p;
    for (int j = 0; j < SQ; j++) begin
      if (j == 0) begin
        rem_p  = '0;
        root_p = '0;
        n_p    = n_q;
      end else begin
        rem_p  = rem_q[j-1];
        root_p = root_q[j-1];
        n_p    = nsh_q[j-1];
      end
      cur   = {rem_p, n_p[gbs_pkg::SQRT_IN_W-1 -: 2]};
      trial = {{(RW+2-SQ-2){1'b0}}, root_p, 2'b01};
      if (cur >= trial) begin
        rem_d[j]  = RW'(cur - trial);
        root_d[j] = {root_p[SQ-2:0], 1'b1};
      end else begin
        rem_d[j]  = cur[RW-1:0];
        root_d[j] = {root_p[SQ-2:0], 1'b0};
      end
      nsh_d[j] = n_p << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < SQ; j++) begin
      rem_q[j]  <= rem_d[j];
      root_q[j] <= root_d[j];
      nsh_q[j]  <= nsh_d[j];
    end
  end

  // Write-back context line
  gbs_pkg::wb_ctx_t ctx_in;

  always_comb begin
    ctx_in.addr      = s1_addr_q;
    ctx_in.upd       = upd;
    ctx_in.count     = s1_word_q.mode ? cnt_new : 8'd0;
    ctx_in.mean      = s1_word_q.mode ? rd_state.mean : x;
    ctx_in.deviation = s1_word_q.mode ? rd_state.deviation : idev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_vld_q <= '0;
    end else begin
      ctx_vld_q <= {ctx_vld_q[NS-2:0], s1_adv};
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q[0].addr      <= ctx_in.addr;
    ctx_q[0].upd       <= ctx_in.upd;
    ctx_q[0].count     <= ctx_in.count;
    ctx_q[0].mean      <= ctx_in.mean;
    ctx_q[0].deviation <= ctx_in.deviation;
    for (int i = 1; i < NS; i++) begin
      ctx_q[i].addr      <= ctx_q[i-1].addr;
      ctx_q[i].upd       <= ctx_q[i-1].upd;
      ctx_q[i].count     <= ctx_q[i-1].count;
      ctx_q[i].deviation <= ctx_q[i-1].deviation;
      // new mean joins the context once the sum stage has it
      if ((i == 2) && ctx_q[1].upd) begin
        ctx_q[i].mean <= nm_q;
      end else begin
        ctx_q[i].mean <= ctx_q[i-1].mean;
      end
    end
  end

  // Rounded deviation and the memory write
  logic [SQ:0] nd_sum;

  always_comb begin
    nd_sum             = ({1'b0, root_q[SQ-1]} + (SQ+1)'(1)) >> 1;
    wr_en              = ctx_vld_q[NS-1];
    wr_state.count     = ctx_q[NS-1].count;
    wr_state.mean      = ctx_q[NS-1].mean;
    if (ctx_q[NS-1].upd) begin
      wr_state.deviation = nd_sum[16] ? 16'hFFFF : nd_sum[15:0];
    end else begin
      wr_state.deviation = ctx_q[NS-1].deviation;
    end
  end

  // Checks
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && wr_en && (ctx_q[NS-1].addr == addr_q)))
    else $error("read issued to an entry being written");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("read stage lost a stalled word");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.last_in_frame) |=> (addr_q == '0))
    else $error("address did not wrap after frame end");

  a_init_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_vld_q[0] && !ctx_q[0].upd && $past(!s1_word_q.mode)) |->
    (ctx_q[0].count == 8'd0))
    else $error("init word left a nonzero counter");

endmodule

@@ tb/sv/tb_gaussian_background_subtractor.sv @@
// Self-checking testbench for gaussian_background_subtractor.
// Drives pixel frames and register writes, predicts every result word with a
// scoreboard class. Depends on gbs_pkg and the RTL of the block.
module tb_gaussian_background_subtractor;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  gbs_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  gbs_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  gaussian_background_subtractor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Per-pixel Gaussian model and queue of predicted words
  class bg_scoreboard;
    logic [15:0] alpha;
    logic [7:0]  ghost_thr;
    logic [15:0] init_dev;
    logic [15:0] mean_mem [int unsigned];
    logic [15:0] dev_mem  [int unsigned];
    logic [7:0]  cnt_mem  [int unsigned];
    int unsigned addr;
    gbs_pkg::out_word_t pending_words[$];
    int          mismatches;
    int          pixels_seen;
    int          words_checked;
    int          fg_words;
    int          ghost_hits;

    function new();
      alpha     = gbs_pkg::LEARNING_RATE_RST;
      ghost_thr = gbs_pkg::GHOST_THRESHOLD_RST;
      init_dev  = gbs_pkg::INITIAL_DEVIATION_RST;
      addr      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] d);
      case (idx)
        gbs_pkg::REG_LEARNING_RATE:     alpha     = d;
        gbs_pkg::REG_GHOST_THRESHOLD:   ghost_thr = d[7:0];
        gbs_pkg::REG_INITIAL_DEVIATION: init_dev  = d;
        default: ;
      endcase
    endfunction

    // Rounded, clamped decision level from a signed 8.8 bound
    function int unsigned to_level(longint v);
      longint r;
      if (v <= 0) return 0;
      r = (v + 128) >>> 8;
      return (r > 255) ? 255 : int'(r);
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_pixel(gbs_pkg::in_word_t w);
      longint m, s, d;
      longint unsigned a, na, x, nm, vr, nd;
      int unsigned lo, hi, cnt;
      logic fg;
      gbs_pkg::out_word_t exp_w;
      pixels_seen++;
      x  = longint'(w.pixel) << 8;
      fg = 1'b0;
      if (!w.mode) begin
        mean_mem[addr] = x[15:0];
        dev_mem[addr]  = init_dev;
        cnt_mem[addr]  = 8'd0;
      end else begin
        m   = mean_mem[addr];
        s   = dev_mem[addr];
        lo  = to_level(m - gbs_pkg::DEVIATION_FACTOR * s);
        hi  = to_level(m + gbs_pkg::DEVIATION_FACTOR * s);
        cnt = cnt_mem[addr];
        fg  = (w.pixel < lo) || (w.pixel > hi);
        if (fg) begin
          if (cnt < 255) cnt++;
          if (cnt > ghost_thr) begin
            fg = 1'b0;
            ghost_hits++;
          end
        end else begin
          cnt = 0;
        end
        cnt_mem[addr] = cnt[7:0];
        if (!fg) begin
          a  = alpha;
          na = 65536 - a;
          d  = longint'(x) - m;
          if (d < 0) d = -d;
          nm = (a * x + na * longint'(m) + 32768) >> 16;
          vr = a * longint'(d * d) + na * longint'(s * s);
          nd = (root_floor(vr >> 14) + 1) >> 1;
          if (nm > 65535) nm = 65535;
          if (nd > 65535) nd = 65535;
          mean_mem[addr] = nm[15:0];
          dev_mem[addr]  = nd[15:0];
        end
      end
      addr = (w.last_in_frame || addr + 1 >= gbs_pkg::FRAME_PIXELS) ? 0 : addr + 1;
      exp_w.foreground        = fg;
      exp_w.last_in_frame_out = w.last_in_frame;
      pending_words.push_back(exp_w);
    endfunction

    function void check_word(gbs_pkg::out_word_t got);
      gbs_pkg::out_word_t exp_w;
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %b", got);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.foreground) fg_words++;
      if (got.foreground !== exp_w.foreground ||
          got.last_in_frame_out !== exp_w.last_in_frame_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: expected fg=%b last=%b, got fg=%b last=%b",
                   words_checked, exp_w.foreground, exp_w.last_in_frame_out,
                   got.foreground, got.last_in_frame_out);
      end
    endfunction
  endclass

  bg_scoreboard sb;

  // Generator side view of addresses and background levels
  bit          gen_ready_map [int unsigned];
  logic [7:0]  gen_level     [int unsigned];
  int unsigned gen_addr;
  bit          calm;
  bit          hold_req;
  int          hold_done;

  // Accepted words on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_pixel(in_data);
    if (rst_ni && out_valid && out_ready) sb.check_word(out_data);
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result sink: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
        hold_done++;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic send_pixel(input logic md, input logic [7:0] pix, input logic lst);
    gbs_pkg::in_word_t w;
    int gap;
    // an address never loaded must be loaded first
    if (!gen_ready_map.exists(gen_addr)) md = 1'b0;
    if (!md) begin
      gen_ready_map[gen_addr] = 1'b1;
      gen_level[gen_addr]     = pix;
    end
    w.mode          = md;
    w.pixel         = pix;
    w.last_in_frame = lst;
    gen_addr        = lst ? 0 : gen_addr + 1;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every predicted word, then for state write-back to land
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Pixel near the stored background most of the time, else anywhere
  function automatic logic [7:0] pick_pixel(int unsigned a);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 40 || !gen_level.exists(a)) return 8'($urandom_range(0, 255));
    v = int'(gen_level[a]) + int'($urandom_range(0, 16)) - 8;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // One init frame, then process frames of up to the same length with some noise
  task automatic run_frames(input int flen, input int nframes);
    int f, p;
    logic md, lst;
    for (p = 0; p < flen; p++) send_pixel(1'b0, 8'($urandom_range(0, 255)), p == flen - 1);
    for (f = 0; f < nframes; f++) begin
      for (p = 0; p < flen; p++) begin
        md  = ($urandom_range(0, 99) < 5) ? 1'b0 : 1'b1;
        lst = (p == flen - 1) || ($urandom_range(0, 99) < 2);
        send_pixel(md, pick_pixel(gen_addr), lst);
        if (lst) break;
      end
    end
  endtask

  function automatic logic [15:0] pick16();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    int ph;
    int unsigned fl;
    logic [15:0] thr_v, idev_v;
    sb        = new();
    gen_addr  = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_done = 0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= gbs_pkg::REG_LEARNING_RATE;
    cfg_data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, default registers, foreground and background
    send_pixel(1'b0, 8'd0,   1'b0);
    send_pixel(1'b0, 8'd255, 1'b0);
    send_pixel(1'b0, 8'd128, 1'b0);
    send_pixel(1'b0, 8'd1,   1'b1);
    send_pixel(1'b1, 8'd0,   1'b0);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd130, 1'b0);
    send_pixel(1'b1, 8'd1,   1'b1);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd0,   1'b0);
    send_pixel(1'b1, 8'd0,   1'b0);
    send_pixel(1'b1, 8'd255, 1'b1);
    drain();
    // Ghost at once: zero threshold, full alpha, zero deviation
    write_reg(gbs_pkg::REG_GHOST_THRESHOLD, 16'd0);
    write_reg(gbs_pkg::REG_LEARNING_RATE, 16'hFFFF);
    write_reg(gbs_pkg::REG_INITIAL_DEVIATION, 16'd0);
    write_reg(2'd3, 16'h1234);
    send_pixel(1'b0, 8'd100, 1'b0);
    send_pixel(1'b0, 8'd200, 1'b1);
    send_pixel(1'b1, 8'd101, 1'b0);
    send_pixel(1'b1, 8'd0,   1'b1);
    send_pixel(1'b1, 8'd255, 1'b0);
    send_pixel(1'b1, 8'd200, 1'b1);
    drain();

    // Counter saturation: one-pixel frames that stay foreground
    write_reg(gbs_pkg::REG_GHOST_THRESHOLD, 16'd255);
    write_reg(gbs_pkg::REG_INITIAL_DEVIATION, 16'd0);
    write_reg(gbs_pkg::REG_LEARNING_RATE, 16'd0);
    send_pixel(1'b0, 8'd0, 1'b1);
    calm = 1'b1;
    repeat (260) send_pixel(1'b1, 8'd255, 1'b1);
    calm = 1'b0;
    drain();

    // Random phases with register sets between them
    for (ph = 0; ph < 5; ph++) begin
      write_reg(gbs_pkg::REG_LEARNING_RATE, pick16());
      if (ph % 3 == 0) thr_v = 16'd255;
      else if ($urandom_range(0, 1) != 0) thr_v = 16'd0;
      else thr_v = 16'($urandom_range(0, 12));
      write_reg(gbs_pkg::REG_GHOST_THRESHOLD, thr_v);
      if ($urandom_range(0, 1) != 0) idev_v = pick16();
      else idev_v = 16'($urandom_range(256, 4096));
      write_reg(gbs_pkg::REG_INITIAL_DEVIATION, idev_v);
      calm = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      fl = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      run_frames(fl, (fl < 4) ? 12 : 60 / fl + 1);
      calm = 1'b0;
      drain();
    end

    $display("%0d pixels sent, %0d words checked, %0d foreground, %0d ghost hits",
             sb.pixels_seen, sb.words_checked, sb.fg_words, sb.ghost_hits);
    $display("long result hold-offs: %0d, mismatches: %0d", hold_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("tb_gaussian_background_subtractor passed");
    end else begin
      $display("tb_gaussian_background_subtractor failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("tb_gaussian_background_subtractor failed");
    $finish;
  end

endmodule
